// File: hw/rtl/ptha_pkg.sv
// Shared types and constants for the per-track hit admission limiter.
`timescale 1ns / 1ps
`default_nettype none
package ptha_pkg;

    // Field widths
    localparam int KEY_W = 31;
    localparam int CNT_W = 16;
    localparam int TRK_W = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults
    localparam int TABLE_DEPTH_DEF = 256;
    localparam logic [CNT_W-1:0] MAX_HITS_RST = 16'd500;
    localparam logic [TRK_W-1:0] MAX_TRACKS_RST = 9'd200;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACKS = 2'd1;

    typedef enum logic [2:0] {
        V_RECORDED    = 3'd0,
        V_NO_DEPOSIT  = 3'd1,
        V_TABLE_FULL  = 3'd2,
        V_TRACK_LIMIT = 3'd3,
        V_CLEARED     = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] trk_id;
        logic             photon;
        logic             deposit_positive;
    } t_in_item;

    typedef struct packed {
        logic             admit;
        t_verdict         verdict;
        logic [CNT_W-1:0] track_hits;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

    // Control broadcast to every cell of the track row
    typedef struct packed {
        logic shift;   // insert a new track at the head, move all entries one cell on
        logic incr;    // bump the count of the matching cell
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: hw/rtl/ptha_stream_if.sv
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none
interface ptha_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/per_track_hit_admission_limiter_core.sv
// Top level: step admission filter built on a shifting row of track cells.
//
//  port    dir  beat payload                                   note
//  i_in    in   command, trk_id, photon, deposit_positive      one item per beat
//  o_out   out  admit, verdict, track_hits                     one result per item
//  i_cfg   in   index, wdata                                   0 max hits, 1 max tracks
//
//  Each item goes through capture, match in every cell, then decide and update
//  the row. The decide step waits while the result register is full and not taken.
//  A result waiting in the output register does not stop the next capture.
//  Reset (synchronous, active low) empties the table and loads 500 / 200 into the
//  registers; a clear command empties the table through the fill count alone.
`timescale 1ns / 1ps
`default_nettype none
module per_track_hit_admission_limiter_core #(
    parameter int TABLE_DEPTH = ptha_pkg::TABLE_DEPTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ptha_stream_if.sink   i_in,
    ptha_stream_if.source o_out,
    ptha_stream_if.sink   i_cfg
);
    import ptha_pkg::*;

    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (UW > TRK_W) ? UW : TRK_W;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [UW-1:0]    r_used, n_used;
    logic [CNT_W-1:0] r_max_hits;
    logic [TRK_W-1:0] r_max_tracks;
    logic             r_out_valid;
    t_out_item        r_out_data, n_out_data;

    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] w_new_cnt;
    logic [KEY_W-1:0] w_key [TABLE_DEPTH];
    logic [CNT_W-1:0] w_cnt [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    logic             w_found;
    logic [CNT_W-1:0] w_sel_cnt;
    logic [LW-1:0]    w_eff_limit;
    logic             w_fire;
    logic             w_accept;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hits   <= MAX_HITS_RST;
            r_max_tracks <= MAX_TRACKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_MAX_HITS:   r_max_hits   <= i_cfg.data.wdata;
                REG_MAX_TRACKS: r_max_tracks <= i_cfg.data.wdata[TRK_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state
    assign w_accept = i_in.valid && i_in.ready;
    assign w_fire   = (r_state == ST_DECIDE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_MATCH;
            ST_MATCH:  n_state = ST_DECIDE;
            ST_DECIDE: if (w_fire) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        i_in.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            default: i_in.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
        end
    end

    // Track row
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        logic [KEY_W-1:0] w_prev_key;
        logic [CNT_W-1:0] w_prev_cnt;
        if (gi == 0) begin : g_head
            assign w_prev_key = r_item.trk_id;
            assign w_prev_cnt = w_new_cnt;
        end else begin : g_link
            assign w_prev_key = w_key[gi-1];
            assign w_prev_cnt = w_cnt[gi-1];
        end
        ptha_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (r_used > UW'(gi)),
            .i_query    (r_item.trk_id),
            .i_prev_key (w_prev_key),
            .i_prev_cnt (w_prev_cnt),
            .o_key      (w_key[gi]),
            .o_cnt      (w_cnt[gi]),
            .o_match    (w_match[gi])
        );
    end

    // Gather the single matching count
    always_comb begin
        w_sel_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_cnt = w_sel_cnt | (w_cnt[i] & {CNT_W{w_match[i]}});
        end
    end
    assign w_found = |w_match;

    assign w_eff_limit = (LW'(r_max_tracks) > LW'(TABLE_DEPTH)) ?
                         LW'(TABLE_DEPTH) : LW'(r_max_tracks);

    // Decide the verdict and the row update
    always_comb begin
        n_used     = r_used;
        w_ctl      = '0;
        w_new_cnt  = (r_max_hits == '0) ? '0 : CNT_W'(1);
        n_out_data = '{admit: 1'b0, verdict: V_CLEARED, track_hits: '0};
        if (r_item.command) begin
            n_used = '0;
        end else if (!r_item.photon) begin
            n_out_data.admit   = r_item.deposit_positive;
            n_out_data.verdict = r_item.deposit_positive ? V_RECORDED : V_NO_DEPOSIT;
        end else if (w_found) begin
            if (w_sel_cnt >= r_max_hits) begin
                n_out_data.verdict    = V_TRACK_LIMIT;
                n_out_data.track_hits = w_sel_cnt;
            end else begin
                w_ctl.incr            = w_fire;
                n_out_data.admit      = 1'b1;
                n_out_data.verdict    = V_RECORDED;
                n_out_data.track_hits = w_sel_cnt + CNT_W'(1);
            end
        end else if (LW'(r_used) >= w_eff_limit) begin
            n_out_data.verdict = V_TABLE_FULL;
        end else begin
            w_ctl.shift           = w_fire;
            n_used                = r_used + UW'(1);
            n_out_data.admit      = (r_max_hits != '0);
            n_out_data.verdict    = (r_max_hits == '0) ? V_TRACK_LIMIT : V_RECORDED;
            n_out_data.track_hits = w_new_cnt;
        end
    end

    // Advance the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_fire) begin
            r_used <= n_used;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Checks
    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> $onehot0(w_match))
        else $error("track id held in more than one cell");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DECIDE))
        else $error("result raised outside the decide step");

    a_row_quiet_off_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DECIDE) |-> (!w_ctl.shift && !w_ctl.incr))
        else $error("track row changed outside the decide step");

endmodule
`default_nettype wire

// File: hw/rtl/ptha_cell.sv
// One entry of the track row: key, hit count and a registered key match.
`timescale 1ns / 1ps
`default_nettype none
module ptha_cell (
    input  wire                          i_clk,
    input  wire  ptha_pkg::t_cell_ctl    i_ctl,
    input  wire                          i_occupied,
    input  wire  [ptha_pkg::KEY_W-1:0]   i_query,
    input  wire  [ptha_pkg::KEY_W-1:0]   i_prev_key,
    input  wire  [ptha_pkg::CNT_W-1:0]   i_prev_cnt,
    output logic [ptha_pkg::KEY_W-1:0]   o_key,
    output logic [ptha_pkg::CNT_W-1:0]   o_cnt,
    output logic                         o_match
);
    import ptha_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_cnt;
    logic             r_match;

    // Compare the held key with the query every cycle
    always_ff @(posedge i_clk) begin
        r_match <= i_occupied && (r_key == i_query);
    end

    // Take the neighbor's entry on insert, else bump the count on a hit
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_prev_key;
            r_cnt <= i_prev_cnt;
        end else if (i_ctl.incr && r_match) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_key   = r_key;
    assign o_cnt   = r_cnt;
    assign o_match = r_match;

endmodule
`default_nettype wire
